>>> hdl/ssid_pkg.sv
`default_nettype none
package ssid_pkg;

  // store depth and the width that holds a count of 0 .. CAPACITY
  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int OUT_CNT_W = 7;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t                    command;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic [OUT_CNT_W-1:0] count;
  } out_item_t;

  // per-cell control, common to the whole row
  typedef struct packed {
    logic cap;   // register compare flags against the incoming key
    logic upd;   // commit the operation
    logic ins;   // committed operation is an insert
    logic del;   // committed operation is a delete
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> hdl/sorted_set_insert_delete_top.sv
`default_nettype none
// Sorted set of up to CAPACITY distinct signed 32-bit keys, held in a row of
// compare-and-shift cells. Each transaction inserts or deletes one key and
// returns one result with a status and the count after the operation. In
// the accept cycle every cell compares its entry with the key and registers
// the outcome; in the apply state the match flags of all cells are reduced
// and, at the commit, each cell shifts from its neighbor or takes the key.
// The commit waits while an earlier result is still stalled in the output
// register. No clearing pass is needed after reset.
module sorted_set_insert_delete_top
  import ssid_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [VAL_W-1:0] key_r;
  cmd_t                    cmd_r;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r;
  status_t                 status_nxt;

  logic                    accept, commit, hit, full, do_ins, do_del;
  cell_ctl_t               ctl;

  logic signed [VAL_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]     gt_vec, eq_vec;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r == S_APPLY);
  assign commit = (state_r == S_APPLY) && (!out_valid_r || !out_stall);

  assign hit    = |eq_vec;
  assign full   = (count_r >= CNT_W'(CAPACITY));
  assign do_ins = commit && (cmd_r == CMD_INSERT) && !hit && !full;
  assign do_del = commit && (cmd_r == CMD_DELETE) && hit;

  assign ctl.cap = accept;
  assign ctl.upd = do_ins || do_del;
  assign ctl.ins = do_ins;
  assign ctl.del = do_del;

  // the cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_gt;
    logic signed [VAL_W-1:0] left_value, right_value;

    if (i == 0) begin : g_first
      assign left_gt    = 1'b0;
      assign left_value = cell_value[i];
    end else begin : g_mid
      assign left_gt    = gt_vec[i-1];
      assign left_value = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    ssid_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cmp_key     (in_data.value),
      .wr_key      (key_r),
      .occupied    (CNT_W'(i) < count_r),
      .at_tail     (CNT_W'(i) == count_r),
      .left_gt     (left_gt),
      .left_value  (left_value),
      .right_value (right_value),
      .value_r     (cell_value[i]),
      .gt_r        (gt_vec[i]),
      .eq_r        (eq_vec[i])
    );
  end

  // sequencer: next state, count and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = ST_NOTFOUND;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (cmd_r == CMD_INSERT) begin
            if (hit) begin
              status_nxt = ST_DUPLICATE;
            end else if (full) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_INSERTED;
              count_nxt  = count_r + CNT_W'(1);
            end
          end else begin
            if (hit) begin
              status_nxt = ST_DELETED;
              count_nxt  = count_r - CNT_W'(1);
            end else begin
              status_nxt = ST_NOTFOUND;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // transaction payload and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_data.value;
      cmd_r <= in_data.command;
    end
    if (commit) begin
      out_data_r.status <= status_nxt;
      out_data_r.count  <= OUT_CNT_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count exceeds capacity");

  // keys are distinct, so at most one cell can match
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> $onehot0(eq_vec))
    else $error("more than one cell matches the key");

  // an insert that lands grows the count by one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not advance the count");

  // a result only appears after a commit
  a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(commit))
    else $error("result without a commit");
`endif

endmodule
`default_nettype wire

>>> hdl/ssid_cell.sv
`default_nettype none
module ssid_cell
  import ssid_pkg::*;
(
  input  wire logic                    clk,
  input  wire cell_ctl_t               ctl,
  input  wire logic signed [VAL_W-1:0] cmp_key,    // key of the incoming transaction
  input  wire logic signed [VAL_W-1:0] wr_key,     // key held for the commit
  input  wire logic                    occupied,   // this slot is below the count
  input  wire logic                    at_tail,    // this slot index equals the count
  input  wire logic                    left_gt,    // lower neighbor holds a value larger than the key
  input  wire logic signed [VAL_W-1:0] left_value,
  input  wire logic signed [VAL_W-1:0] right_value,
  output logic signed [VAL_W-1:0]      value_r,
  output logic                         gt_r,
  output logic                         eq_r
);

  logic signed [VAL_W-1:0] value_nxt;

  // compare flags, taken when a transaction is accepted
  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      gt_r <= occupied && (value_r > cmp_key);
      eq_r <= occupied && (value_r == cmp_key);
    end
  end

  // insert: shift up above the key, key lands at the first larger slot or the tail
  // delete: every occupied slot from the match upward takes its upper neighbor
  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      if (left_gt) begin
        value_nxt = left_value;
      end else if (gt_r || at_tail) begin
        value_nxt = wr_key;
      end
    end else if (ctl.del) begin
      if (gt_r || eq_r) begin
        value_nxt = right_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd) begin
      value_r <= value_nxt;
    end
  end

endmodule
`default_nettype wire
